/* hdl/bbi_pkg.sv */
// Package for the block bit interleaver: beat types, cell control struct,
// state encoding and the row-width decode. No dependencies.
`default_nettype none

package bbi_pkg;

	localparam int DATA_W       = 8;
	localparam int CFG_W        = 4;
	localparam int MAX_ROWS_DEF = 64;

	localparam logic [CFG_W-1:0] BPR_RESET = 4'd8;

	typedef struct packed {
		logic [DATA_W-1:0] row_byte;
		logic              last_row;
	} item_t;

	typedef struct packed {
		logic [DATA_W-1:0] out_word;
		logic              last_word;
		logic              truncated;
	} result_t;

	// Broadcast control for the row of cells
	typedef struct packed {
		logic load;
		logic rotate;
		logic clear;
	} ctl_t;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	// Width minus one; a width outside 1..8 means 8
	function automatic logic [2:0] width_m1(input logic [CFG_W-1:0] bpr);
		logic [2:0] w;
		if (bpr == 4'd0 || bpr > 4'd8) begin
			w = 3'd7;
		end else begin
			w = 3'(bpr - 4'd1);
		end
		return w;
	endfunction

endpackage

`default_nettype wire

/* hdl/bbi_cell.sv */
// One cell of the row chain: holds one stored row and its valid flag.
// Depends on bbi_pkg for the control struct and data width.
`default_nettype none

module bbi_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bbi_pkg::ctl_t             ctl,
	input  logic [bbi_pkg::DATA_W-1:0] data,
	input  logic                      prev_valid,
	input  logic                      next_valid,
	input  logic [bbi_pkg::DATA_W-1:0] next_row,
	input  logic [bbi_pkg::DATA_W-1:0] head_row,
	output logic                      valid,
	output logic [bbi_pkg::DATA_W-1:0] row
);
	import bbi_pkg::*;

	logic              valid_q;
	logic [DATA_W-1:0] row_q;
	logic              capture;

	// The first empty cell takes the broadcast row
	assign capture = ctl.load && !valid_q && prev_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (capture) begin
			valid_q <= 1'b1;
		end
	end

	// Rotate towards the head; the last filled cell takes the head row back
	always_ff @(posedge clk) begin
		if (capture) begin
			row_q <= data;
		end else if (ctl.rotate && valid_q) begin
			row_q <= next_valid ? next_row : head_row;
		end
	end

	assign valid = valid_q;
	assign row   = row_q;

endmodule

`default_nettype wire

/* hdl/block_bit_interleaver.sv */
// Top level of the block bit interleaver: chain of row cells, readout
// sequencer and word packer. Depends on bbi_pkg and bbi_cell.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------
//  input    | start / busy            | item   (row_byte, last_row)
//  output   | result_strobe (1 cycle) | result (out_word, last_word, truncated)
//  config   | cfg_we                  | cfg_wdata (bits_per_row)
//
// Flow: a row beat is taken when start is high while idle; the beat marked
// last_row also starts readout of b * n bits (b bits per row, n stored rows),
// one bit per cycle out of the head cell of the chain, with busy high for
// the whole readout. A word leaves each time b bits have been packed.
// Reset: arst_n clears the state, counts and cell valid flags; row data is
// not cleared. The receiver cannot stall: each word is shown for one cycle.
`default_nettype none

module block_bit_interleaver #(
	parameter int MAX_ROWS = bbi_pkg::MAX_ROWS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  bbi_pkg::item_t            item,
	output logic                      busy,
	input  logic                      cfg_we,
	input  logic [bbi_pkg::CFG_W-1:0] cfg_wdata,
	output bbi_pkg::result_t          result,
	output logic                      result_strobe
);
	import bbi_pkg::*;

	localparam int CNT_W = $clog2(MAX_ROWS + 1);

	state_t            state_q, state_d;
	ctl_t              ctl;
	logic [CFG_W-1:0]  bpr_q;
	logic [CNT_W-1:0]  count_q;
	logic              ovf_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  r_q;
	logic [2:0]        col_q;
	logic [2:0]        bm1_q;
	logic [2:0]        filled_q;
	logic [DATA_W-1:0] acc_q;
	logic              trunc_q;
	result_t           result_q;
	logic              strobe_q;

	logic              accept;
	logic              full;
	logic              head_bit;
	logic [DATA_W-1:0] acc_next;
	logic              row_wrap;
	logic              last_bit;
	logic              word_done;

	logic [DATA_W-1:0] row_w   [MAX_ROWS];
	logic              valid_w [MAX_ROWS];

	// ---------------------------------------------------------------
	// Row chain: a beat is broadcast and lands in the first empty cell,
	// so row r of the block sits in cell r. During readout the chain
	// rotates by one each cycle, the head row wrapping to the last
	// filled cell, so the head walks the rows in arrival order.
	// ---------------------------------------------------------------
	for (genvar i = 0; i < MAX_ROWS; i++) begin : g_cell
		logic              prev_v;
		logic              next_v;
		logic [DATA_W-1:0] next_r;

		if (i == 0) begin : g_first
			assign prev_v = 1'b1;
		end else begin : g_mid
			assign prev_v = valid_w[i-1];
		end

		if (i == MAX_ROWS - 1) begin : g_last
			assign next_v = 1'b0;
			assign next_r = '0;
		end else begin : g_inner
			assign next_v = valid_w[i+1];
			assign next_r = row_w[i+1];
		end

		bbi_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.data       (item.row_byte),
			.prev_valid (prev_v),
			.next_valid (next_v),
			.next_row   (next_r),
			.head_row   (row_w[0]),
			.valid      (valid_w[i]),
			.row        (row_w[i])
		);
	end

	// ---------------------------------------------------------------
	// Readout bookkeeping
	// ---------------------------------------------------------------
	assign accept    = start && (state_q == ST_IDLE);
	assign full      = (count_q == CNT_W'(MAX_ROWS));
	assign head_bit  = row_w[0][col_q];
	assign acc_next  = {acc_q[DATA_W-2:0], head_bit};
	assign row_wrap  = (r_q == n_q - CNT_W'(1));
	assign last_bit  = row_wrap && (col_q == 3'd0);
	assign word_done = (filled_q == bm1_q);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && item.last_row) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (last_bit) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State outputs: cell control and busy
	always_comb begin
		ctl  = '0;
		busy = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				ctl.load = start;
			end
			ST_EMIT: begin
				busy       = 1'b1;
				ctl.rotate = 1'b1;
				ctl.clear  = last_bit;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			bpr_q    <= BPR_RESET;
			count_q  <= '0;
			ovf_q    <= 1'b0;
			strobe_q <= 1'b0;
			r_q      <= '0;
			col_q    <= '0;
			filled_q <= '0;
		end else begin
			state_q  <= state_d;
			strobe_q <= 1'b0;
			if (cfg_we) begin
				bpr_q <= cfg_wdata;
			end
			if (accept) begin
				// Count the row in, or drop it and mark the block truncated
				if (!full) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
				if (item.last_row) begin
					r_q      <= '0;
					col_q    <= width_m1(bpr_q);
					filled_q <= '0;
				end
			end
			if (state_q == ST_EMIT) begin
				// Advance row within the column, then drop to the next column
				if (row_wrap) begin
					r_q   <= '0;
					col_q <= col_q - 3'd1;
				end else begin
					r_q <= r_q + CNT_W'(1);
				end
				if (word_done) begin
					filled_q <= '0;
					strobe_q <= 1'b1;
				end else begin
					filled_q <= filled_q + 3'd1;
				end
				if (last_bit) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
				end
			end
		end
	end

	// Payload registers: sample width, row total and truncation at the
	// final row, then pack bits into the accumulator
	always_ff @(posedge clk) begin
		if (accept && item.last_row) begin
			n_q     <= full ? count_q : count_q + CNT_W'(1);
			trunc_q <= ovf_q || full;
			bm1_q   <= width_m1(bpr_q);
			acc_q   <= '0;
		end
		if (state_q == ST_EMIT) begin
			if (word_done) begin
				acc_q              <= '0;
				result_q.out_word  <= acc_next;
				result_q.last_word <= last_bit;
				result_q.truncated <= trunc_q;
			end else begin
				acc_q <= acc_next;
			end
		end
	end

	assign result        = result_q;
	assign result_strobe = strobe_q;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	a_strobe_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(busy))
		else $error("word strobe without a readout cycle before it");

	a_last_ends_block: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && result.last_word) |-> !busy)
		else $error("final word shown while readout still running");

	a_last_row_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.last_row) |=> busy)
		else $error("final row beat did not start readout");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ROWS))
		else $error("row count beyond chain length");

	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> valid_w[0])
		else $error("readout from an empty head cell");

endmodule

`default_nettype wire
